### rtl/core/rtcab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtcab_pkg;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  localparam logic [3:0] ACCESS_WORD = 4'd4;

  localparam logic [15:0] OFF_TIME_LO  = 16'h0000;
  localparam logic [15:0] OFF_TIME_HI  = 16'h0004;
  localparam logic [15:0] OFF_ALARM_LO = 16'h0008;
  localparam logic [15:0] OFF_ALARM_HI = 16'h000C;
  localparam logic [15:0] OFF_CTRL     = 16'h0010;
  localparam logic [15:0] OFF_STATUS   = 16'h0014;

  localparam logic RESP_OK        = 1'b0;
  localparam logic RESP_BAD_ALIGN = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] offset;
    logic [31:0] write_data;
    logic [3:0]  access_bytes;
  } rtcab_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        response;
    logic        alarm_pending;
  } rtcab_result_t;

endpackage

`default_nettype wire

### rtl/core/rtcab_regfile.sv
`timescale 1ns / 1ps
`default_nettype none

module rtcab_regfile
  import rtcab_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          enable,
  input  wire rtcab_item_t   item,
  output rtcab_result_t      result
);

  logic [63:0] elapsed_us;
  logic [31:0] time_word_low;
  logic [31:0] time_word_high;
  logic [31:0] alarm_word_low;
  logic [31:0] alarm_word_high;
  logic [31:0] control_word;
  logic        alarm_flag;

  logic [63:0] elapsed_us_next;
  logic [31:0] time_word_low_next;
  logic [31:0] time_word_high_next;
  logic [31:0] alarm_word_low_next;
  logic [31:0] alarm_word_high_next;
  logic [31:0] control_word_next;
  logic        alarm_flag_next;

  logic [63:0] elapsed_inc;
  logic        width_ok;
  logic [31:0] rd;
  logic        resp;

  assign elapsed_inc = elapsed_us + 64'd1;
  assign width_ok    = (item.access_bytes == ACCESS_WORD);

  always_comb begin
    elapsed_us_next      = elapsed_us;
    time_word_low_next   = time_word_low;
    time_word_high_next  = time_word_high;
    alarm_word_low_next  = alarm_word_low;
    alarm_word_high_next = alarm_word_high;
    control_word_next    = control_word;
    alarm_flag_next      = alarm_flag;
    rd                   = 32'd0;
    resp                 = RESP_OK;
    case (item.action)
      ACT_TICK: begin
        elapsed_us_next     = elapsed_inc;
        time_word_low_next  = elapsed_inc[31:0];
        time_word_high_next = elapsed_inc[63:32];
        if (control_word[0] && (elapsed_inc >= {alarm_word_high, alarm_word_low})) begin
          alarm_flag_next = 1'b1;
        end
      end
      ACT_READ: begin
        if (!width_ok) begin
          resp = RESP_BAD_ALIGN;
        end else begin
          case (item.offset)
            OFF_TIME_LO:  rd = time_word_low;
            OFF_TIME_HI:  rd = time_word_high;
            OFF_ALARM_LO: rd = alarm_word_low;
            OFF_ALARM_HI: rd = alarm_word_high;
            OFF_CTRL:     rd = control_word;
            OFF_STATUS:   rd = {31'd0, alarm_flag};
            default:      rd = 32'd0;
          endcase
        end
      end
      ACT_WRITE: begin
        if (!width_ok) begin
          resp = RESP_BAD_ALIGN;
        end else begin
          case (item.offset)
            OFF_TIME_LO:  time_word_low_next   = item.write_data;
            OFF_TIME_HI:  time_word_high_next  = item.write_data;
            OFF_ALARM_LO: alarm_word_low_next  = item.write_data;
            OFF_ALARM_HI: alarm_word_high_next = item.write_data;
            OFF_CTRL:     control_word_next    = item.write_data;
            OFF_STATUS:   alarm_flag_next      = alarm_flag & ~item.write_data[0];
            default:      ;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign result.read_data     = rd;
  assign result.response      = resp;
  assign result.alarm_pending = alarm_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_us      <= 64'd0;
      time_word_low   <= 32'd0;
      time_word_high  <= 32'd0;
      alarm_word_low  <= 32'd0;
      alarm_word_high <= 32'd0;
      control_word    <= 32'd0;
      alarm_flag      <= 1'b0;
    end else if (enable) begin
      elapsed_us      <= elapsed_us_next;
      time_word_low   <= time_word_low_next;
      time_word_high  <= time_word_high_next;
      alarm_word_low  <= alarm_word_low_next;
      alarm_word_high <= alarm_word_high_next;
      control_word    <= control_word_next;
      alarm_flag      <= alarm_flag_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rtc_alarm_register_block.sv
// Memory-mapped real-time clock with a 64-bit alarm.
// Input channel (in_valid / in_stall): one transaction per event, selected by
// action: a microsecond tick, a bus read or a bus write of offset/write_data.
// Only 4-byte accesses are taken; other widths return response 1, no effect.
// Output channel (out_valid / out_stall): exactly one result per input
// transaction, in order: read_data, response and the alarm flag after the
// event.
// Path: the input register holds the accepted transaction; the register file
// update and the result register are loaded at the same edge.
// Throughput: one transaction per cycle while out_stall is low; the register
// update (a 64-bit increment and alarm compare on a tick) is combinational.
// Stall: while out_stall holds a result, the input register keeps the next
// transaction and in_stall rises once it is occupied.
// Reset: rst clears all clock, alarm, control and status registers to zero
// and empties both pipeline registers.
`timescale 1ns / 1ps
`default_nettype none

module rtc_alarm_register_block
  import rtcab_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  action,
  input  wire logic [15:0] offset,
  input  wire logic [31:0] write_data,
  input  wire logic [3:0]  access_bytes,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      read_data,
  output logic             response,
  output logic             alarm_pending
);

  logic          item_valid;
  rtcab_item_t   item;
  rtcab_result_t result;
  logic          advance;
  logic          fire;
  logic          take;

  assign advance  = !out_valid || !out_stall;
  assign fire     = item_valid && advance;
  assign in_stall = item_valid && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  // hold the transaction until the result register frees
  always_ff @(posedge clk) begin
    if (take) begin
      item.action       <= action;
      item.offset       <= offset;
      item.write_data   <= write_data;
      item.access_bytes <= access_bytes;
    end
  end

  rtcab_regfile u_regfile (
    .clk    (clk),
    .rst    (rst),
    .enable (fire),
    .item   (item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_data     <= result.read_data;
      response      <= result.response;
      alarm_pending <= result.alarm_pending;
    end
  end

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rtcab_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTED = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_TICK;
  logic [15:0] offset = '0;
  logic [31:0] write_data = '0;
  logic [3:0]  access_bytes = ACCESS_WORD;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_data;
  logic        response;
  logic        alarm_pending;

  rtc_alarm_register_block i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .offset        (offset),
    .write_data    (write_data),
    .access_bytes  (access_bytes),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_data     (read_data),
    .response      (response),
    .alarm_pending (alarm_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the clock and register file
  logic [63:0] us_count;
  logic [31:0] time_lo, time_hi, alarm_lo, alarm_hi, ctrl_reg;
  logic        alarm_flag;

  rtcab_result_t pending_results[$];
  int mismatches = 0;
  int cycle_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int n_tick = 0, n_read = 0, n_write = 0, n_rejected = 0, n_alarm_set = 0, n_checked = 0;

  function automatic int burst_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic rtcab_result_t apply_event(rtcab_item_t it);
    rtcab_result_t r;
    r = '0;
    if (it.action == ACT_TICK) begin
      us_count = us_count + 64'd1;
      time_lo = us_count[31:0];
      time_hi = us_count[63:32];
      if (ctrl_reg[0] && us_count >= {alarm_hi, alarm_lo}) alarm_flag = 1'b1;
    end else if (it.action == ACT_READ || it.action == ACT_WRITE) begin
      if (it.access_bytes != ACCESS_WORD) begin
        r.response = RESP_BAD_ALIGN;
      end else if (it.action == ACT_READ) begin
        case (it.offset)
          OFF_TIME_LO:  r.read_data = time_lo;
          OFF_TIME_HI:  r.read_data = time_hi;
          OFF_ALARM_LO: r.read_data = alarm_lo;
          OFF_ALARM_HI: r.read_data = alarm_hi;
          OFF_CTRL:     r.read_data = ctrl_reg;
          OFF_STATUS:   r.read_data = {31'd0, alarm_flag};
          default:      r.read_data = '0;
        endcase
      end else begin
        case (it.offset)
          OFF_TIME_LO:  time_lo = it.write_data;
          OFF_TIME_HI:  time_hi = it.write_data;
          OFF_ALARM_LO: alarm_lo = it.write_data;
          OFF_ALARM_HI: alarm_hi = it.write_data;
          OFF_CTRL:     ctrl_reg = it.write_data;
          OFF_STATUS:   alarm_flag = alarm_flag & ~it.write_data[0];
          default:      ;
        endcase
      end
    end
    r.alarm_pending = alarm_flag;
    return r;
  endfunction

  task automatic flag_field(input string name, input logic [31:0] exp, input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTED)
      $display("mismatch on %s at cycle %0d: expected %h, got %h", name, cycle_count, exp, got);
  endtask

  // Predict on acceptance, compare on each result transaction
  always @(posedge clk) begin
    rtcab_item_t   it;
    rtcab_result_t exp;
    logic          was_set;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end else if (rst) begin
      us_count = '0;
      time_lo = '0;
      time_hi = '0;
      alarm_lo = '0;
      alarm_hi = '0;
      ctrl_reg = '0;
      alarm_flag = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          flag_field("unexpected result", '0, read_data);
        end else begin
          exp = pending_results.pop_front();
          n_checked++;
          if (read_data !== exp.read_data) flag_field("read_data", exp.read_data, read_data);
          if (response !== exp.response)
            flag_field("response", 32'(exp.response), 32'(response));
          if (alarm_pending !== exp.alarm_pending)
            flag_field("alarm_pending", 32'(exp.alarm_pending), 32'(alarm_pending));
        end
      end
      if (in_valid && !in_stall) begin
        it = '{action: action, offset: offset, write_data: write_data,
               access_bytes: access_bytes};
        was_set = alarm_flag;
        pending_results.push_back(apply_event(it));
        if (!was_set && alarm_flag) n_alarm_set++;
        if (action == ACT_TICK) n_tick++;
        else if (action == ACT_SPARE || access_bytes != ACCESS_WORD) n_rejected++;
        else if (action == ACT_READ) n_read++;
        else n_write++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= burst_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_item(input logic [1:0] act, input logic [15:0] off,
                           input logic [31:0] wdata, input logic [3:0] nbytes);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < gap_pct) gap = burst_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    offset <= off;
    write_data <= wdata;
    access_bytes <= nbytes;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic bus_wr(input logic [15:0] off, input logic [31:0] wdata);
    send_item(ACT_WRITE, off, wdata, ACCESS_WORD);
  endtask

  task automatic bus_rd(input logic [15:0] off);
    send_item(ACT_READ, off, $urandom, ACCESS_WORD);
  endtask

  task automatic tick();
    send_item(ACT_TICK, 16'($urandom), $urandom, 4'($urandom));
  endtask

  task automatic test_reset_state();
    bus_rd(OFF_TIME_LO);
    bus_rd(OFF_CTRL);
    bus_rd(OFF_STATUS);
  endtask

  task automatic test_register_extremes();
    bus_wr(OFF_TIME_HI, 32'hFFFF_FFFF);
    bus_rd(OFF_TIME_HI);
    tick();
    bus_rd(OFF_TIME_HI);
    bus_wr(OFF_ALARM_HI, 32'hFFFF_FFFF);
    bus_wr(OFF_CTRL, 32'hFFFF_FFFF);
    tick();
  endtask

  task automatic test_access_errors();
    send_item(ACT_READ, OFF_TIME_LO, '0, 4'd0);
    send_item(ACT_WRITE, OFF_CTRL, '0, 4'd15);
    send_item(ACT_READ, OFF_CTRL, '0, 4'd8);
    bus_rd(16'hFFFF);
    bus_wr(16'h0013, 32'hFFFF_FFFF);
    bus_rd(16'h0002);
    send_item(ACT_SPARE, OFF_CTRL, 32'hFFFF_FFFF, ACCESS_WORD);
  endtask

  task automatic test_alarm_flag();
    bus_wr(OFF_ALARM_HI, 32'h0);
    tick();
    bus_wr(OFF_STATUS, 32'hFFFF_FFFE);
    bus_wr(OFF_STATUS, 32'h1);
    bus_wr(OFF_CTRL, 32'h0);
    tick();
    bus_rd(OFF_STATUS);
  endtask

  task automatic test_random_traffic(input int n_items, input int gaps, input int stalls);
    logic [15:0] mapped[6];
    logic [1:0]  act;
    logic [15:0] off;
    logic [31:0] wdata;
    logic [3:0]  nbytes;
    int          r;
    mapped = '{OFF_TIME_LO, OFF_TIME_HI, OFF_ALARM_LO, OFF_ALARM_HI, OFF_CTRL, OFF_STATUS};
    gap_pct = gaps;
    stall_pct = stalls;
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      off = ($urandom_range(0, 99) < 85) ? mapped[$urandom_range(0, 5)] : 16'($urandom);
      nbytes = ($urandom_range(0, 99) < 95) ? ACCESS_WORD : 4'($urandom);
      wdata = $urandom;
      if (off == OFF_ALARM_LO && $urandom_range(0, 99) < 80)
        wdata = us_count[31:0] + $urandom_range(0, 40) - 32'd10;
      else if (off == OFF_ALARM_HI && $urandom_range(0, 99) < 80)
        wdata = '0;
      if (r < 35) act = ACT_TICK;
      else if (r < 65) act = ACT_READ;
      else if (r < 95) act = ACT_WRITE;
      else act = ACT_SPARE;
      send_item(act, off, wdata, nbytes);
    end
  endtask

  initial begin
    int drain;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gap_pct = 20;
    stall_pct = 20;
    test_reset_state();
    test_register_extremes();
    test_access_errors();
    test_alarm_flag();
    test_random_traffic(500, 0, 0);
    test_random_traffic(550, 35, 35);
    test_random_traffic(550, 10, 60);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 8) begin
      @(posedge clk);
      drain++;
    end
    $display("checked %0d results: %0d ticks, %0d reads, %0d writes, %0d rejected or spare",
             n_checked, n_tick, n_read, n_write, n_rejected);
    $display("alarm flag raised %0d times, %0d mismatches", n_alarm_set, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
